/* rtl/priority_voice_allocator_defines.svh */
// Assertion macros for the priority voice allocator.
`ifndef PRIORITY_VOICE_ALLOCATOR_DEFINES_SVH
`define PRIORITY_VOICE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define PVA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pva: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PVA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pva: next-cycle check failed");

`else

`define PVA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PVA_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/pva_pkg.sv */
// Shared types and codes of the priority voice allocator.
package pva_pkg;

   typedef logic [1:0] command_type;
   localparam command_type CMD_PLAY    = 2'd0;
   localparam command_type CMD_FINISH  = 2'd1;
   localparam command_type CMD_RELEASE = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_REFUSED    = 2'd1;
   localparam status_type ST_NO_VOICE   = 2'd2;
   localparam status_type ST_START_FAIL = 2'd3;

   typedef enum logic [1:0] {
      KIND_FREE,
      KIND_REPLY,
      KIND_PLAY
   } kind_type;

   // Request payload, last field in the lowest bits.
   typedef struct packed {
      logic [1:0]  pad;
      logic [31:0] now_time;
      logic        start_fails;
      logic        loop;
      logic [15:0] buffer_id;
      logic [7:0]  priority_req;
      logic [3:0]  voice_sel;
   } req_data_type;

   // Response payload, last field in the lowest bits.
   typedef struct packed {
      logic        pad;
      logic [15:0] buffer_out;
      logic        reused;
      logic [3:0]  voice_out;
      status_type  status;
   } rsp_data_type;

   // Classified item passed from the front end to the back end.
   typedef struct packed {
      kind_type    kind;
      status_type  status;
      logic [3:0]  voice_sel;
      logic [7:0]  priority_req;
      logic [15:0] buffer_id;
      logic        loop;
      logic        start_fails;
      logic [31:0] now_time;
   } entry_type;

endpackage

/* rtl/pva_front.sv */
// Front end: decodes and classifies incoming items.
module pva_front #(
   parameter int NUM_VOICES = 16
) (
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          req_tuser,
   input  logic [63:0]         req_tdata,
   input  logic                mute,
   output logic                push_valid,
   input  logic                push_ready,
   output pva_pkg::entry_type  push_entry
);
   import pva_pkg::*;

   req_data_type req;
   logic         sel_bad;

   assign req        = req_data_type'(req_tdata);
   assign sel_bad    = ({28'd0, req.voice_sel} >= 32'(NUM_VOICES));
   assign req_tready = push_ready;
   assign push_valid = req_tvalid;

   always_comb begin
      push_entry              = '0;
      push_entry.voice_sel    = req.voice_sel;
      push_entry.priority_req = req.priority_req;
      push_entry.buffer_id    = req.buffer_id;
      push_entry.loop         = req.loop;
      push_entry.start_fails  = req.start_fails;
      push_entry.now_time     = req.now_time;
      priority if (req_tuser == CMD_FINISH || req_tuser == CMD_RELEASE) begin
         if (sel_bad) begin
            push_entry.kind   = KIND_REPLY;
            push_entry.status = ST_NO_VOICE;
         end else begin
            push_entry.kind   = KIND_FREE;
            push_entry.status = ST_OK;
         end
      end else if (req_tuser != CMD_PLAY || mute || req.buffer_id == 16'd0) begin
         // refused: nothing but the status goes out
         push_entry.kind      = KIND_REPLY;
         push_entry.status    = ST_REFUSED;
         push_entry.voice_sel = 4'd0;
      end else begin
         push_entry.kind   = KIND_PLAY;
         push_entry.status = ST_OK;
      end
   end

endmodule

/* rtl/pva_queue.sv */
// Two-entry queue between the front end and the back end.
module pva_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  pva_pkg::entry_type in_entry,
   output logic               out_valid,
   input  logic               out_ready,
   output pva_pkg::entry_type out_entry
);
   import pva_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_entry = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            slot_ff[wr_ptr_ff] <= in_entry;
            wr_ptr_ff          <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

/* rtl/pva_back.sv */
// Back end: voice state, allocation scan and response register.
module pva_back #(
   parameter int NUM_VOICES    = 16,
   parameter int PRIORITY_BITS = 8,
   parameter int TIME_BITS     = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  pva_pkg::entry_type q_entry,
   output logic               busy,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata
);
   import pva_pkg::*;

   localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int PW = PRIORITY_BITS;
   localparam int TW = TIME_BITS;

   typedef enum logic [1:0] {
      MODE_FREE,
      MODE_PLAY,
      MODE_LOOP
   } mode_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_RESOLVE
   } state_type;

   state_type          state_ff;
   entry_type          op_ff;
   logic [VW-1:0]      scan_idx_ff;
   logic [VW-1:0]      cmp_idx_ff;
   logic               cmp_valid_ff;
   mode_type           mode_rd_ff;
   logic [PW+TW-1:0]   rd_ff;
   logic               have_free_ff;
   logic [VW-1:0]      free_idx_ff;
   logic               have_victim_ff;
   logic [VW-1:0]      best_idx_ff;
   logic [PW-1:0]      best_prio_ff;
   logic [TW-1:0]      best_time_ff;
   logic               rsp_valid_ff;
   rsp_data_type       rsp_data_ff;

   mode_type           mode_ff [NUM_VOICES];
   logic [PW+TW-1:0]   mem [NUM_VOICES];

   logic [PW-1:0]      op_prio;
   logic [TW-1:0]      op_time;
   logic [PW-1:0]      rd_prio;
   logic [TW-1:0]      rd_time;
   logic               take_free;
   logic               take_victim;
   logic               res_fire;
   rsp_data_type       res_data;
   logic               mode_we;
   logic [VW-1:0]      mode_wr_idx;
   mode_type           mode_wr_val;
   logic               mem_we;

   assign op_prio = PW'(op_ff.priority_req);
   assign op_time = TW'(op_ff.now_time);
   assign rd_prio = rd_ff[PW+TW-1:TW];
   assign rd_time = rd_ff[TW-1:0];

   assign q_ready    = (state_ff == S_IDLE);
   assign busy       = (state_ff != S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign res_fire   = (state_ff == S_RESOLVE) && (!rsp_valid_ff || rsp_tready);

   // compare stage: first free voice, and best victim (lowest priority, then oldest)
   assign take_free = cmp_valid_ff && (mode_rd_ff == MODE_FREE) && !have_free_ff;
   assign take_victim = cmp_valid_ff && (mode_rd_ff == MODE_PLAY) && (rd_prio <= op_prio)
                        && (!have_victim_ff || rd_prio < best_prio_ff
                            || (rd_prio == best_prio_ff && rd_time < best_time_ff));

   always_comb begin
      logic [VW-1:0] found_idx;
      found_idx   = have_free_ff ? free_idx_ff : best_idx_ff;
      res_data    = '0;
      mode_we     = 1'b0;
      mode_wr_idx = VW'(op_ff.voice_sel);
      mode_wr_val = MODE_FREE;
      mem_we      = 1'b0;
      unique case (op_ff.kind)
         KIND_FREE: begin
            res_data.status    = ST_OK;
            res_data.voice_out = op_ff.voice_sel;
            mode_we            = res_fire;
         end
         KIND_REPLY: begin
            res_data.status    = op_ff.status;
            res_data.voice_out = op_ff.voice_sel;
         end
         KIND_PLAY: begin
            if (!have_free_ff && !have_victim_ff) begin
               res_data.status = ST_NO_VOICE;
            end else begin
               res_data.voice_out = 4'(found_idx);
               res_data.reused    = !have_free_ff;
               mode_we            = res_fire;
               mode_wr_idx        = found_idx;
               if (op_ff.start_fails) begin
                  // leave the voice free, keep its priority and time
                  res_data.status = ST_START_FAIL;
               end else begin
                  res_data.status     = ST_OK;
                  res_data.buffer_out = op_ff.buffer_id;
                  mode_wr_val         = op_ff.loop ? MODE_LOOP : MODE_PLAY;
                  mem_we              = res_fire;
               end
            end
         end
         default: begin
            res_data.status = ST_REFUSED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VOICES; i++) begin
            mode_ff[i] <= MODE_FREE;
         end
      end else if (mode_we) begin
         mode_ff[mode_wr_idx] <= mode_wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mode_wr_idx] <= {op_prio, op_time};
      end
      rd_ff      <= mem[scan_idx_ff];
      mode_rd_ff <= mode_ff[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         cmp_valid_ff   <= 1'b0;
         have_free_ff   <= 1'b0;
         have_victim_ff <= 1'b0;
         scan_idx_ff    <= '0;
      end else begin
         cmp_valid_ff <= (state_ff == S_SCAN);
         if (res_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (take_free) begin
            have_free_ff <= 1'b1;
            free_idx_ff  <= cmp_idx_ff;
         end
         if (take_victim) begin
            have_victim_ff <= 1'b1;
            best_idx_ff    <= cmp_idx_ff;
            best_prio_ff   <= rd_prio;
            best_time_ff   <= rd_time;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  op_ff          <= q_entry;
                  have_free_ff   <= 1'b0;
                  have_victim_ff <= 1'b0;
                  scan_idx_ff    <= '0;
                  state_ff       <= (q_entry.kind == KIND_PLAY) ? S_SCAN : S_RESOLVE;
               end
            end
            S_SCAN: begin
               cmp_idx_ff <= scan_idx_ff;
               if (scan_idx_ff == VW'(NUM_VOICES - 1)) begin
                  state_ff <= S_DRAIN;
               end else begin
                  scan_idx_ff <= scan_idx_ff + VW'(1);
               end
            end
            S_DRAIN: begin
               // last compare lands this cycle
               state_ff <= S_RESOLVE;
            end
            S_RESOLVE: begin
               if (res_fire) begin
                  rsp_data_ff <= res_data;
                  state_ff    <= S_IDLE;
               end
            end
         endcase
      end
   end

endmodule

/* rtl/priority_voice_allocator.sv */
// Top level of the priority voice allocator.
//
//   channel  dir  handshake                 payload
//   req      in   req_tvalid / req_tready   req_tuser command, req_tdata request fields
//   rsp      out  rsp_tvalid / rsp_tready   rsp_tdata status, voice, reused, buffer
//   csr      in   csr_valid / csr_ready     csr_data mute
//
// In the back end a play request reads one voice per cycle through the state memory
// read port, then passes a compare drain state and a resolve state.
// Finish, release and refused items go from idle straight to the resolve state.
// A two-entry queue lets the front end take items while the back end scans or
// while a response waits on rsp_tready.
// Reset clears all voice modes to free directly; there is no clearing pass.
`include "priority_voice_allocator_defines.svh"

module priority_voice_allocator #(
   parameter int NUM_VOICES    = 16,
   parameter int PRIORITY_BITS = 8,
   parameter int TIME_BITS     = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] command
   // [3:0] voice_sel, [11:4] priority_req, [27:12] buffer_id, [28] loop,
   // [29] start_fails, [61:30] now_time, [63:62] zero
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [5:2] voice_out, [6] reused, [22:7] buffer_out, [23] zero
   output logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);
   import pva_pkg::*;

   logic      mute_ff;
   logic      mute_in;
   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;
   logic      q_valid;
   logic      q_ready;
   entry_type q_entry;
   logic      back_busy;
   logic      req_fire;

   assign csr_ready = 1'b1;
   assign mute_in   = (csr_valid && csr_ready) ? csr_data : mute_ff;
   assign req_fire  = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mute_ff <= 1'b0;
      end else begin
         mute_ff <= mute_in;
      end
   end

   pva_front #(
      .NUM_VOICES (NUM_VOICES)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .mute       (mute_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   pva_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_entry (q_entry)
   );

   pva_back #(
      .NUM_VOICES    (NUM_VOICES),
      .PRIORITY_BITS (PRIORITY_BITS),
      .TIME_BITS     (TIME_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_entry    (q_entry),
      .busy       (back_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // an accepted item is either queued or being worked on in the next cycle
   `PVA_ASSERT_NXT(a_item_held, clock, reset, req_fire, q_valid || back_busy)
   // a failed start hands out no buffer
   `PVA_ASSERT_IMP(a_fail_no_buffer, clock, reset, rsp_tvalid && rsp_tdata[1:0] == ST_START_FAIL, rsp_tdata[22:7] == 16'd0)
   // a stolen voice is only reported with a grant or a failed start
   `PVA_ASSERT_IMP(a_reused_grant, clock, reset, rsp_tvalid && rsp_tdata[6], rsp_tdata[1:0] == ST_OK || rsp_tdata[1:0] == ST_START_FAIL)

endmodule

/* dv/tb_priority_voice_allocator.sv */
// Testbench for the priority voice allocator: directed and random requests against a scoreboard.
`timescale 1ns / 1ps

module tb_priority_voice_allocator;
   import pva_pkg::*;

   localparam command_type CMD_UNKNOWN = 2'd3;

   typedef enum logic [1:0] {
      VOICE_FREE,
      VOICE_PLAYING,
      VOICE_LOOPING
   } voice_mode_type;

   class voice_ledger;
      localparam int VOICES = 16;

      voice_mode_type mode_of[VOICES];
      logic [7:0]     prio_of[VOICES];
      logic [31:0]    start_of[VOICES];
      bit             muted;
      rsp_data_type   expected_replies[$];

      int errors;
      int items;
      int grants;
      int steals;
      int start_failures;
      int refusals;
      int no_voice;

      function new();
         for (int i = 0; i < VOICES; i++) begin
            mode_of[i]  = VOICE_FREE;
            prio_of[i]  = '0;
            start_of[i] = '0;
         end
         muted = 1'b0;
      endfunction

      function void set_mute(bit value);
         muted = value;
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      task flag_mismatch(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      // Work out the reply to one accepted item and advance the voice table.
      function void note_request(command_type cmd, req_data_type d);
         rsp_data_type reply;
         int           found;
         bit           have_victim;
         logic [7:0]   best_prio;
         logic [31:0]  best_start;

         reply       = '0;
         found       = -1;
         have_victim = 1'b0;
         best_prio   = '0;
         best_start  = '0;
         items++;

         if (cmd == CMD_FINISH || cmd == CMD_RELEASE) begin
            mode_of[d.voice_sel] = VOICE_FREE;
            reply.status    = ST_OK;
            reply.voice_out = d.voice_sel;
         end else if (cmd != CMD_PLAY || muted || d.buffer_id == '0) begin
            reply.status = ST_REFUSED;
            refusals++;
         end else begin
            // scan downward so the lowest free index wins
            for (int i = VOICES - 1; i >= 0; i--)
               if (mode_of[i] == VOICE_FREE) found = i;
            if (found < 0) begin
               for (int i = 0; i < VOICES; i++) begin
                  if (mode_of[i] == VOICE_PLAYING && prio_of[i] <= d.priority_req &&
                      (!have_victim || prio_of[i] < best_prio ||
                       (prio_of[i] == best_prio && start_of[i] < best_start))) begin
                     have_victim = 1'b1;
                     best_prio   = prio_of[i];
                     best_start  = start_of[i];
                     found       = i;
                  end
               end
            end
            if (found < 0) begin
               reply.status = ST_NO_VOICE;
               no_voice++;
            end else begin
               reply.voice_out = found[3:0];
               reply.reused    = have_victim;
               if (have_victim) steals++;
               if (d.start_fails) begin
                  mode_of[found] = VOICE_FREE;
                  reply.status   = ST_START_FAIL;
                  start_failures++;
               end else begin
                  mode_of[found]   = d.loop ? VOICE_LOOPING : VOICE_PLAYING;
                  prio_of[found]   = d.priority_req;
                  start_of[found]  = d.now_time;
                  reply.status     = ST_OK;
                  reply.buffer_out = d.buffer_id;
                  grants++;
               end
            end
         end
         expected_replies.insert(expected_replies.size(), reply);
      endfunction

      task check_reply(rsp_data_type got);
         rsp_data_type want;
         if (expected_replies.size() == 0) begin
            flag_mismatch($sformatf("reply %h with nothing expected", got));
            return;
         end
         want = expected_replies.pop_front();
         if (got.status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.voice_out !== want.voice_out)
            flag_mismatch($sformatf("voice %0d, want %0d", got.voice_out, want.voice_out));
         if (got.reused !== want.reused)
            flag_mismatch($sformatf("reused %0d, want %0d", got.reused, want.reused));
         if (got.buffer_out !== want.buffer_out)
            flag_mismatch($sformatf("buffer %h, want %h", got.buffer_out, want.buffer_out));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b0;

   voice_ledger sb;
   bit          steady = 1'b0;
   logic [31:0] ticks = '0;
   int          mute_writes = 0;

   priority_voice_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Reply side: check each accepted item, stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_reply(rsp_data_type'(rsp_tdata));
      rsp_tready <= steady || ($urandom_range(0, 99) >= 19);
   end

   function automatic req_data_type make_req(logic [3:0] sel, logic [7:0] prio,
                                             logic [15:0] buffer, bit loop, bit fails,
                                             logic [31:0] now);
      req_data_type d;
      d              = '0;
      d.voice_sel    = sel;
      d.priority_req = prio;
      d.buffer_id    = buffer;
      d.loop         = loop;
      d.start_fails  = fails;
      d.now_time     = now;
      return d;
   endfunction

   task automatic send_item(command_type cmd, req_data_type d);
      while (!steady && $urandom_range(0, 99) < 19) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, d);
   endtask

   task automatic play(logic [7:0] prio, logic [15:0] buffer, bit loop, bit fails,
                       logic [31:0] now);
      send_item(CMD_PLAY, make_req(4'd0, prio, buffer, loop, fails, now));
   endtask

   // Write mute once every reply is back and the block sits idle.
   task automatic write_mute(bit value);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_mute(value);
      mute_writes++;
      csr_valid <= 1'b0;
   endtask

   task automatic random_item();
      command_type  cmd;
      req_data_type d;
      int           roll;
      roll = $urandom_range(0, 99);
      if (roll < 58)      cmd = CMD_PLAY;
      else if (roll < 78) cmd = CMD_FINISH;
      else if (roll < 97) cmd = CMD_RELEASE;
      else                cmd = CMD_UNKNOWN;
      // few distinct priorities and repeated ticks give plenty of ties
      ticks = ticks + $urandom_range(0, 3);
      d = make_req(4'($urandom), ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                             : 8'($urandom_range(0, 3) * 85),
                   ($urandom_range(0, 99) < 5) ? 16'd0 : 16'($urandom),
                   $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 8,
                   ($urandom_range(0, 9) == 0) ? 32'($urandom) : ticks);
      send_item(cmd, d);
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      write_mute(1'b0);
      play(8'd10, 16'd0, 1'b0, 1'b0, 32'd1);
      send_item(CMD_UNKNOWN, make_req(4'd15, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 32'hFFFF_FFFF));
      play(8'd9, 16'd77, 1'b0, 1'b1, 32'd2);
      // fill every voice; voices 0, 4, 8 and 12 share the lowest priority
      for (int i = 0; i < 16; i++)
         play((i % 4 == 0) ? 8'd1 : 8'(16 * i + 15), (i == 2) ? 16'hFFFF : 16'(i + 1),
              i == 3 || i == 12, 1'b0,
              (i == 8) ? 32'd3 : (i % 4 == 0) ? 32'd7 : (i == 1) ? 32'hFFFF_FFFF : 32'(3 * i));
      play(8'd0, 16'd500, 1'b0, 1'b0, 32'd100);      // nothing low enough to steal
      play(8'd1, 16'd501, 1'b0, 1'b0, 32'd100);      // oldest of the lowest
      play(8'd1, 16'd502, 1'b0, 1'b0, 32'd100);      // tie goes to the lowest index
      play(8'd255, 16'd503, 1'b0, 1'b1, 32'd0);      // stolen voice left free
      play(8'd200, 16'd504, 1'b1, 1'b0, 32'd101);
      send_item(CMD_RELEASE, make_req(4'd3, 8'd0, 16'd0, 1'b0, 1'b0, 32'd0));
      send_item(CMD_FINISH, make_req(4'd15, 8'd0, 16'd0, 1'b0, 1'b0, 32'd0));

      write_mute(1'b1);
      play(8'd255, 16'hFFFF, 1'b0, 1'b0, 32'd200);
      send_item(CMD_FINISH, make_req(4'd2, 8'd0, 16'd0, 1'b0, 1'b0, 32'd0));
      write_mute(1'b0);

      ticks = 32'd1000;
      for (int n = 0; n < 200; n++) begin
         steady = (n >= 60 && n < 140);
         random_item();
      end
      steady = 1'b0;
      write_mute(1'b1);
      for (int n = 0; n < 30; n++) random_item();
      write_mute(1'b0);
      for (int n = 0; n < 220; n++) random_item();

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("ran %0d items: %0d grants, %0d steals, %0d start failures",
               sb.items, sb.grants, sb.steals, sb.start_failures);
      $display("%0d refused, %0d found no voice, %0d mute writes",
               sb.refusals, sb.no_voice, mute_writes);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #4_800_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/pva_pkg.sv
rtl/pva_front.sv
rtl/pva_queue.sv
rtl/pva_back.sv
rtl/priority_voice_allocator.sv
dv/tb_priority_voice_allocator.sv
